### rtl/core/expression_tokenizer_top_macros.svh
// ----------------------------------------------------------------------------
// Expression tokenizer assertion macros
// Shorthand for clocked properties with the async reset masked.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`define EXPRESSION_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication
`define ETOK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETOK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/etok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Token kinds, character classes, keyword table and the result item type.
// ----------------------------------------------------------------------------
package etok_pkg;

	localparam logic [4:0] KIND_END     = 5'd0;
	localparam logic [4:0] KIND_PLUS    = 5'd1;
	localparam logic [4:0] KIND_MINUS   = 5'd2;
	localparam logic [4:0] KIND_DIV     = 5'd3;
	localparam logic [4:0] KIND_MUL     = 5'd4;
	localparam logic [4:0] KIND_ASSIGN  = 5'd5;
	localparam logic [4:0] KIND_COMMA   = 5'd6;
	localparam logic [4:0] KIND_LBRACK  = 5'd7;
	localparam logic [4:0] KIND_RBRACK  = 5'd8;
	localparam logic [4:0] KIND_LPAREN  = 5'd9;
	localparam logic [4:0] KIND_RPAREN  = 5'd10;
	localparam logic [4:0] KIND_GREATER = 5'd11;
	localparam logic [4:0] KIND_LESS    = 5'd12;
	localparam logic [4:0] KIND_NOTEQ   = 5'd13;
	localparam logic [4:0] KIND_NUM     = 5'd14;
	localparam logic [4:0] KIND_ID      = 5'd15;
	localparam logic [4:0] KIND_EXP     = 5'd16;
	localparam logic [4:0] KIND_SIN     = 5'd17;
	localparam logic [4:0] KIND_COS     = 5'd18;
	localparam logic [4:0] KIND_TAN     = 5'd19;
	localparam logic [4:0] KIND_ARCSIN  = 5'd20;
	localparam logic [4:0] KIND_ARCCOS  = 5'd21;
	localparam logic [4:0] KIND_ARCTAN  = 5'd22;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_GREATER = 8'h3E;

	localparam logic [7:0] KW_SHORT_LEN = 8'd3;
	localparam logic [7:0] KW_LONG_LEN  = 8'd6;

	// first character in the low byte
	localparam logic [63:0] KW_EXP_TEXT    = 64'h0000_0000_0070_7865;
	localparam logic [63:0] KW_SIN_TEXT    = 64'h0000_0000_006E_6973;
	localparam logic [63:0] KW_COS_TEXT    = 64'h0000_0000_0073_6F63;
	localparam logic [63:0] KW_TAN_TEXT    = 64'h0000_0000_006E_6174;
	localparam logic [63:0] KW_ARCSIN_TEXT = 64'h0000_6E69_7363_7261;
	localparam logic [63:0] KW_ARCCOS_TEXT = 64'h0000_736F_6363_7261;
	localparam logic [63:0] KW_ARCTAN_TEXT = 64'h0000_6E61_7463_7261;

	localparam int RESQ_DEPTH  = 4;
	localparam int RESQ_WRITES = 3;

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] num_value;
		logic [63:0] name_chars;
		logic [7:0]  name_len;
		logic        is_error;
		logic        final_res;
	} res_t;

	typedef struct packed {
		logic [1:0]                   cnt;
		res_t [RESQ_WRITES-1:0]       items;
	} res_wr_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return ch inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] ch);
		return (ch inside {[8'h61:8'h7A]}) || (ch inside {[8'h41:8'h5A]});
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return (ch == 8'h20) || (ch inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic [4:0] op_kind(input logic [7:0] ch);
		logic [4:0] k;
		case (ch)
			"+": k = KIND_PLUS;
			"-": k = KIND_MINUS;
			"/": k = KIND_DIV;
			"*": k = KIND_MUL;
			"=": k = KIND_ASSIGN;
			",": k = KIND_COMMA;
			"[": k = KIND_LBRACK;
			"]": k = KIND_RBRACK;
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			">": k = KIND_GREATER;
			default: k = KIND_END;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] kw_kind(input logic [63:0] chars, input logic [7:0] len);
		logic [4:0] k;
		k = KIND_ID;
		if (len == KW_SHORT_LEN) begin
			if (chars == KW_EXP_TEXT)      k = KIND_EXP;
			else if (chars == KW_SIN_TEXT) k = KIND_SIN;
			else if (chars == KW_COS_TEXT) k = KIND_COS;
			else if (chars == KW_TAN_TEXT) k = KIND_TAN;
		end else if (len == KW_LONG_LEN) begin
			if (chars == KW_ARCSIN_TEXT)      k = KIND_ARCSIN;
			else if (chars == KW_ARCCOS_TEXT) k = KIND_ARCCOS;
			else if (chars == KW_ARCTAN_TEXT) k = KIND_ARCTAN;
		end
		return k;
	endfunction

endpackage

### rtl/core/etok_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression tokenizer scanner
// Input register, scan state and the per-character token logic.
// ----------------------------------------------------------------------------
module etok_lexer #(
	parameter int NAME_CHARS = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ch,
	input  logic              last,
	input  logic              space_ok,
	output etok_pkg::res_wr_t wr
);
	import etok_pkg::*;

	localparam int CHAR_BITS = 8 * NAME_CHARS;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_NUM  = 2'd1;
	localparam logic [1:0] MODE_NAME = 2'd2;
	localparam logic [1:0] MODE_LESS = 2'd3;

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  last_s1;
	logic [1:0]            mode_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CHAR_BITS-1:0]  chars_q;
	logic [7:0]            len_q;

	logic                  advance;
	logic [7:0]            diff;
	logic [3:0]            dig;
	logic [VALUE_BITS+3:0] prod;
	logic [VALUE_BITS-1:0] acc_value;
	logic [CHAR_BITS-1:0]  app_chars;
	logic [7:0]            len_inc;
	logic [4:0]            opk;

	logic [1:0]            m1, m2;
	logic [VALUE_BITS-1:0] v1, v2;
	logic [CHAR_BITS-1:0]  c1, c2;
	logic [7:0]            l1, l2;
	logic                  fresh;
	logic                  va, vb, vc;
	res_t                  res_a, res_b, res_c;

	function automatic res_t flush_res(input logic [1:0] m, input logic [VALUE_BITS-1:0] v,
			input logic [CHAR_BITS-1:0] c, input logic [7:0] l);
		res_t r;
		logic [63:0] w;
		r = '0;
		w = 64'(v);
		case (m)
			MODE_NUM: begin
				r.kind = KIND_NUM;
				r.num_value = w[31:0];
			end
			MODE_NAME: begin
				r.kind = kw_kind(64'(c), l);
				r.name_chars = 64'(c);
				r.name_len = l;
			end
			MODE_LESS: r.kind = KIND_LESS;
			default: r.kind = KIND_END;
		endcase
		return r;
	endfunction

	assign advance  = valid_s1 & space_ok;
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// digit accumulate: value * 10 + d, saturate on carry out
	always_comb begin
		diff = ch_s1 - CH_ZERO;
		dig  = diff[3:0];
		prod = {1'b0, value_q, 3'b000} + {3'b000, value_q, 1'b0}
			+ {{VALUE_BITS{1'b0}}, dig};
		acc_value = (|prod[VALUE_BITS+3:VALUE_BITS]) ? VALUE_MAX : prod[VALUE_BITS-1:0];
		len_inc = (len_q == 8'hFF) ? len_q : len_q + 8'd1;
		app_chars = chars_q;
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (len_q == 8'(i)) app_chars[8*i +: 8] = ch_s1;
		end
		opk = op_kind(ch_s1);
	end

	always_comb begin
		m1 = mode_q;
		v1 = value_q;
		c1 = chars_q;
		l1 = len_q;
		fresh = 1'b1;
		va = 1'b0;
		res_a = '0;
		if (mode_q == MODE_NUM && is_digit(ch_s1)) begin
			v1 = acc_value;
			fresh = 1'b0;
		end else if (mode_q == MODE_NAME && (is_alpha(ch_s1) || is_digit(ch_s1))) begin
			c1 = app_chars;
			l1 = len_inc;
			fresh = 1'b0;
		end else if (mode_q == MODE_LESS && ch_s1 == CH_GREATER) begin
			res_a.kind = KIND_NOTEQ;
			va = 1'b1;
			m1 = MODE_IDLE;
			v1 = '0;
			c1 = '0;
			l1 = '0;
			fresh = 1'b0;
		end else if (mode_q != MODE_IDLE) begin
			res_a = flush_res(mode_q, value_q, chars_q, len_q);
			va = 1'b1;
			m1 = MODE_IDLE;
			v1 = '0;
			c1 = '0;
			l1 = '0;
		end

		m2 = m1;
		v2 = v1;
		c2 = c1;
		l2 = l1;
		vb = 1'b0;
		res_b = '0;
		if (fresh && !is_space(ch_s1)) begin
			if (opk != KIND_END) begin
				res_b.kind = opk;
				vb = 1'b1;
			end else if (ch_s1 == CH_LESS) begin
				m2 = MODE_LESS;
			end else if (ch_s1 == CH_ZERO) begin
				res_b.kind = KIND_NUM;
				vb = 1'b1;
			end else if (is_digit(ch_s1)) begin
				m2 = MODE_NUM;
				v2 = VALUE_BITS'(dig);
			end else if (is_alpha(ch_s1)) begin
				m2 = MODE_NAME;
				c2 = CHAR_BITS'(ch_s1);
				l2 = 8'd1;
			end else begin
				res_b.is_error = 1'b1;
				vb = 1'b1;
			end
		end

		// flush what is still open on the final character, then end
		if (last_s1 && m2 != MODE_IDLE) begin
			res_b = flush_res(m2, v2, c2, l2);
			vb = 1'b1;
		end
		vc = last_s1;
		res_c = '0;
		res_c.kind = KIND_END;
		res_c.final_res = 1'b1;

		wr.items[0] = va ? res_a : (vb ? res_b : res_c);
		wr.items[1] = va ? (vb ? res_b : res_c) : res_c;
		wr.items[2] = res_c;
		wr.cnt = advance ? (2'(va) + 2'(vb) + 2'(vc)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			value_q <= '0;
			chars_q <= '0;
			len_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				mode_q  <= MODE_IDLE;
				value_q <= '0;
				chars_q <= '0;
				len_q   <= '0;
			end else begin
				mode_q  <= m2;
				value_q <= v2;
				chars_q <= c2;
				len_q   <= l2;
			end
		end
	end

endmodule

### rtl/core/etok_resq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression tokenizer result queue
// Four-entry queue taking up to three tokens a cycle, draining one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module etok_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  etok_pkg::res_wr_t wr,
	output logic              space_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output etok_pkg::res_t    out_item
);
	import etok_pkg::*;

	localparam int PTR_BITS = $clog2(RESQ_DEPTH);
	localparam int CNT_BITS = $clog2(RESQ_DEPTH + 1);

	res_t                mem_q [RESQ_DEPTH];
	logic [PTR_BITS-1:0] wp_q;
	logic [PTR_BITS-1:0] rp_q;
	logic [CNT_BITS-1:0] count_q;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rp_q];
	assign pop       = out_valid & out_ready;
	assign space_ok  = (count_q <= CNT_BITS'(RESQ_DEPTH - RESQ_WRITES));

	always_ff @(posedge clk) begin
		for (int k = 0; k < RESQ_WRITES; k++) begin
			if (2'(k) < wr.cnt) mem_q[wp_q + PTR_BITS'(k)] <= wr.items[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PTR_BITS'(wr.cnt);
			rp_q    <= rp_q + PTR_BITS'(pop);
			count_q <= count_q + CNT_BITS'(wr.cnt) - CNT_BITS'(pop);
		end
	end

endmodule

### rtl/core/expression_tokenizer_top.sv
// Path: an item is registered on acceptance and its tokens are written into the
// result queue once the queue has room; m_axis shows the queue head directly.
// Throughput: one item per cycle while items average one token or fewer and
// m_axis_tready stays high; the output port moves one token per cycle while
// ready; the four-entry result queue stalls input while it holds more than one
// token. Reset: arst_n clears scan state and the queue at once; no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression tokenizer
// Streams characters in and tokens out.
// ----------------------------------------------------------------------------
module expression_tokenizer_top #(
	parameter int NAME_CHARS = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // ch
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // num_value, name_chars, name_len
	output logic [5:0]   m_axis_tuser,   // kind, is_error
	output logic         m_axis_tlast
);
	import etok_pkg::*;

	res_wr_t wr;
	logic    space_ok;
	res_t    out_item;

	etok_lexer #(
		.NAME_CHARS(NAME_CHARS),
		.VALUE_BITS(VALUE_BITS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.ch       (s_axis_tdata),
		.last     (s_axis_tlast),
		.space_ok (space_ok),
		.wr       (wr)
	);

	etok_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.space_ok  (space_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {out_item.name_len, out_item.name_chars, out_item.num_value};
	assign m_axis_tuser = {out_item.is_error, out_item.kind};
	assign m_axis_tlast = out_item.final_res;

endmodule

### rtl/core/etok_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression tokenizer port checker
// Token field consistency and output hold, bound to the top level.
// ----------------------------------------------------------------------------
`include "expression_tokenizer_top_macros.svh"

module etok_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic [5:0]   m_axis_tuser,
	input logic         m_axis_tlast
);
	import etok_pkg::*;

	`ETOK_ASSERT_IMP(a_end_tok, m_axis_tvalid && m_axis_tlast, m_axis_tuser[4:0] == KIND_END && !m_axis_tuser[5] && m_axis_tdata == '0, "end item carries data")
	`ETOK_ASSERT_IMP(a_err_tok, m_axis_tvalid && m_axis_tuser[5], m_axis_tuser[4:0] == KIND_END && !m_axis_tlast && m_axis_tdata == '0, "malformed error item")
	`ETOK_ASSERT_IMP(a_num_only, m_axis_tvalid && m_axis_tuser[4:0] != KIND_NUM, m_axis_tdata[31:0] == 32'd0, "value on non-number item")
	`ETOK_ASSERT_IMP(a_name_only, m_axis_tvalid && m_axis_tuser[4:0] < KIND_ID, m_axis_tdata[103:32] == 72'd0, "name on non-name item")
	`ETOK_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled item changed")

endmodule

bind expression_tokenizer_top etok_checker u_etok_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
